>>> sv/stellar_disk_limb_darkening_defines.svh
// ---------------------------------------------------------------------------
// stellar disk limb darkening assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef STELLAR_DISK_LIMB_DARKENING_DEFINES_SVH
`define STELLAR_DISK_LIMB_DARKENING_DEFINES_SVH

// same-cycle implication
`define SDLD_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sdld assertion failed");

// next-cycle implication
`define SDLD_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sdld assertion failed");

`endif

>>> sv/sdld_pkg.sv
// ---------------------------------------------------------------------------
// sdld_pkg
// field widths, register indexes, mode codes and law constants
// ---------------------------------------------------------------------------
package sdld_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int POS_W   = 18;
    localparam int INT_W   = 32;
    localparam int COEFF_W = 20;
    localparam int MODE_W  = 3;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 32;
    localparam int NORM_W  = 34;
    localparam int K_W     = 8;

    localparam logic [CFG_IW-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_INTENSITY = 3'd1;
    localparam logic [CFG_IW-1:0] REG_COEFF1    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_COEFF2    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_COEFF3    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_COEFF4    = 3'd5;

    localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNIFORM   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUAD      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NONLINEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DAYNIGHT  = 3'd4;

    // quadratic law, everything scaled by 6
    localparam int QUAD_K  = 6;
    localparam int QUAD_C1 = 2;
    localparam int QUAD_C2 = 1;

    // four coefficient law, everything scaled by 210
    localparam int NL_K  = 210;
    localparam int NL_C1 = 42;
    localparam int NL_C2 = 70;
    localparam int NL_C3 = 90;
    localparam int NL_C4 = 105;

endpackage

>>> sv/sdld_isqrt.sv
// ---------------------------------------------------------------------------
// sdld_isqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module sdld_isqrt #(
    parameter int W   = 33,
    parameter int SBW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [W-1:0]         radicand,
    input  logic [SBW-1:0]       side_in,
    output logic                 out_valid,
    output logic [(W+1)/2-1:0]   root,
    output logic [SBW-1:0]       side_out
);

    localparam int NS = (W + 1) / 2;

    logic           valid_reg [NS];
    logic [W-1:0]   v_reg     [NS];
    logic [W-1:0]   r_reg     [NS];
    logic [SBW-1:0] side_reg  [NS];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic [W:0] BIT = (W+1)'(1) << (2 * (NS - 1 - i));
        logic           valid_prev;
        logic [W-1:0]   v_prev;
        logic [W-1:0]   r_prev;
        logic [SBW-1:0] side_prev;
        logic [W:0]     trial;
        logic [W-1:0]   v_next;
        logic [W-1:0]   r_next;

        if (i == 0) begin : g_first
            assign valid_prev = in_valid;
            assign v_prev     = radicand;
            assign r_prev     = '0;
            assign side_prev  = side_in;
        end
        else begin : g_rest
            assign valid_prev = valid_reg[i-1];
            assign v_prev     = v_reg[i-1];
            assign r_prev     = r_reg[i-1];
            assign side_prev  = side_reg[i-1];
        end

        always_comb
        begin
            trial = {1'b0, r_prev} + BIT;
            if ({1'b0, v_prev} >= trial)
            begin
                v_next = v_prev - trial[W-1:0];
                r_next = (r_prev >> 1) + BIT[W-1:0];
            end
            else
            begin
                v_next = v_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i]    <= v_next;
                r_reg[i]    <= r_next;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign root      = r_reg[NS-1][NS-1:0];
    assign side_out  = side_reg[NS-1];

`include "stellar_disk_limb_darkening_defines.svh"

    `SDLD_ASSERT_NXT(a_isqrt_hold, !en, $stable(out_valid) && $stable(root))

endmodule

>>> sv/sdld_divider.sv
// ---------------------------------------------------------------------------
// sdld_divider
// pipelined restoring divider with quotient overflow detect
// ---------------------------------------------------------------------------
module sdld_divider #(
    parameter int DW  = 50,
    parameter int QW  = 32,
    parameter int SBW = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DW+QW-1:0]   num,
    input  logic [DW-1:0]      divisor,
    input  logic [SBW-1:0]     side_in,
    output logic               out_valid,
    output logic [QW-1:0]      quot,
    output logic [DW-1:0]      rem,
    output logic               ovf,
    output logic [SBW-1:0]     side_out
);

    logic           valid_reg [QW+1];
    logic [DW-1:0]  rem_reg   [QW+1];
    logic [QW-1:0]  low_reg   [QW+1];
    logic [QW-1:0]  q_reg     [QW+1];
    logic           ovf_reg   [QW+1];
    logic [SBW-1:0] side_reg  [QW+1];

    // first stage: quotient that needs more than QW bits saturates anyway
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0]  <= num >= {divisor, {QW{1'b0}}};
            rem_reg[0]  <= num[DW+QW-1:QW];
            low_reg[0]  <= num[QW-1:0];
            q_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0]   trial;
        logic          take;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], low_reg[k-1][QW-1]};
            take     = trial >= {1'b0, divisor};
            rem_next = take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= {low_reg[k-1][QW-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][QW-2:0], take};
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quot      = q_reg[QW];
    assign rem       = rem_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

`include "stellar_disk_limb_darkening_defines.svh"

    `SDLD_ASSERT_IMP(a_div_rem_range, out_valid && !ovf, rem < divisor)

endmodule

>>> sv/stellar_disk_limb_darkening.sv
// ---------------------------------------------------------------------------
// stellar_disk_limb_darkening
// surface brightness of a limb-darkened stellar disk at a sky-plane point
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_stall    pos_x, pos_y
//  result    out_valid / out_stall  brightness, undefined
//  config    cfg_write              cfg_index, cfg_data
//
//  one point enters per cycle while the output is not stalled; the pipeline depth is
//  set by the two square root pipelines and the 33 stage divider
//  stall freezes the whole pipeline; in_stall is high while a result waits
//  rst_n clears the valid bits and the configuration registers
// ---------------------------------------------------------------------------
module stellar_disk_limb_darkening #(
    parameter int FRAC_BITS = sdld_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sdld_pkg::POS_W-1:0]   pos_x,
    input  logic signed [sdld_pkg::POS_W-1:0]   pos_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sdld_pkg::INT_W-1:0]   brightness,
    output logic                                undefined,
    input  logic                                cfg_write,
    input  logic [sdld_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [sdld_pkg::CFG_DW-1:0]         cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int XW   = sdld_pkg::POS_W;
    localparam int IW   = sdld_pkg::INT_W;
    localparam int CW   = sdld_pkg::COEFF_W;
    localparam int NW   = sdld_pkg::NORM_W;
    localparam int KW   = sdld_pkg::K_W;
    localparam int SQW  = 2 * XW;
    localparam int SW   = 2 * F + 1;
    localparam int RW   = (SW > SQW) ? SW : SQW;
    localparam int MW   = F + 1;
    localparam int PW   = 2 * MW;
    localparam int CPW  = CW + MW + 1;
    localparam int LW   = F + 26;
    localparam int LKW  = LW + KW;
    localparam int H    = (LKW + 1) / 2;
    localparam int HH   = LKW - H;
    localparam int PLW  = IW + H;
    localparam int PHW  = IW + HH;
    localparam int DW   = NW + F;
    localparam int QW   = IW;
    localparam int NNW  = DW + QW;

    localparam logic [RW-1:0]        ONE2_R = RW'(1) << (2 * F);
    localparam logic [MW-1:0]        ONE_M  = MW'(1) << F;
    localparam logic [PW-1:0]        HALF_P = PW'(1) << (F - 1);
    localparam logic signed [LW-1:0] ONE2_L = LW'(1) << (2 * F);
    localparam logic signed [NW-1:0] ONE_N  = NW'(1) << F;

    // configuration registers
    logic [sdld_pkg::MODE_W-1:0] mode_reg;
    logic signed [IW-1:0]        intensity_reg;
    logic signed [CW-1:0]        coeff1_reg;
    logic signed [CW-1:0]        coeff2_reg;
    logic signed [CW-1:0]        coeff3_reg;
    logic signed [CW-1:0]        coeff4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sdld_pkg::MODE_NONE;
            intensity_reg <= '0;
            coeff1_reg    <= '0;
            coeff2_reg    <= '0;
            coeff3_reg    <= '0;
            coeff4_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sdld_pkg::REG_MODE:      mode_reg      <= cfg_data[sdld_pkg::MODE_W-1:0];
                sdld_pkg::REG_INTENSITY: intensity_reg <= cfg_data[IW-1:0];
                sdld_pkg::REG_COEFF1:    coeff1_reg    <= cfg_data[CW-1:0];
                sdld_pkg::REG_COEFF2:    coeff2_reg    <= cfg_data[CW-1:0];
                sdld_pkg::REG_COEFF3:    coeff3_reg    <= cfg_data[CW-1:0];
                sdld_pkg::REG_COEFF4:    coeff4_reg    <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // values derived from the configuration in two register steps,
    // settled long before an item needs them
    logic signed [NW-1:0] norm_next;
    logic signed [NW-1:0] norm_reg;
    logic [NW-1:0]        norm_mag;
    logic [DW-1:0]        divisor_reg;
    logic                 norm_neg_reg;
    logic                 norm_zero_reg;
    logic [IW-1:0]        int_mag_reg;
    logic                 int_neg_reg;
    logic                 nonlinear;
    logic [KW-1:0]        k_scale;

    assign nonlinear = (mode_reg == sdld_pkg::MODE_NONLINEAR);
    assign k_scale   = nonlinear ? KW'(sdld_pkg::NL_K) : KW'(sdld_pkg::QUAD_K);

    always_comb
    begin
        if (nonlinear)
        begin
            norm_next = NW'(sdld_pkg::NL_K) * ONE_N
                      - NW'(sdld_pkg::NL_C1) * NW'(coeff1_reg)
                      - NW'(sdld_pkg::NL_C2) * NW'(coeff2_reg)
                      - NW'(sdld_pkg::NL_C3) * NW'(coeff3_reg)
                      - NW'(sdld_pkg::NL_C4) * NW'(coeff4_reg);
        end
        else
        begin
            norm_next = NW'(sdld_pkg::QUAD_K) * ONE_N
                      - NW'(sdld_pkg::QUAD_C1) * NW'(coeff1_reg)
                      - NW'(sdld_pkg::QUAD_C2) * NW'(coeff2_reg);
        end
    end

    assign norm_mag = norm_reg[NW-1] ? NW'(-norm_reg) : norm_reg;

    always_ff @(posedge clk)
    begin
        norm_reg      <= norm_next;
        divisor_reg   <= DW'(norm_mag) << F;
        norm_neg_reg  <= norm_reg[NW-1];
        norm_zero_reg <= (norm_reg == '0);
        int_mag_reg   <= intensity_reg[IW-1] ? IW'(-intensity_reg) : intensity_reg;
        int_neg_reg   <= intensity_reg[IW-1];
    end

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // a: capture, b: squares, c: radius test and 1 - r^2
    logic                 a_valid_reg, b_valid_reg, c_valid_reg;
    logic signed [XW-1:0] a_x_reg, a_y_reg;
    logic [SQW-1:0]       b_sqx_reg, b_sqy_reg;
    logic [SW-1:0]        c_v_reg;
    logic                 c_out_reg;
    logic [RW-1:0]        rsq;

    assign rsq = RW'(b_sqx_reg) + RW'(b_sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg   <= pos_x;
            a_y_reg   <= pos_y;
            b_sqx_reg <= a_x_reg * a_x_reg;
            b_sqy_reg <= a_y_reg * a_y_reg;
            c_out_reg <= rsq > ONE2_R;
            c_v_reg   <= SW'(ONE2_R - rsq);
        end
    end

    // mu = sqrt(1 - r^2), then s = sqrt(mu)
    logic          mu_valid;
    logic [MW-1:0] mu;
    logic          mu_out;
    logic          s_valid;
    logic [MW-1:0] s_root;
    logic [MW:0]   s_side;

    sdld_isqrt #(
        .W   (SW),
        .SBW (1)
    ) u_mu_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .radicand  (c_v_reg),
        .side_in   (c_out_reg),
        .out_valid (mu_valid),
        .root      (mu),
        .side_out  (mu_out)
    );

    sdld_isqrt #(
        .W   (SW),
        .SBW (MW + 1)
    ) u_s_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mu_valid),
        .radicand  ({mu, {F{1'b0}}}),
        .side_in   ({mu_out, mu}),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    // e: squares and mu*s, f: rounding and law terms
    logic          e_valid_reg, f_valid_reg;
    logic          e_out_reg, f_out_reg;
    logic [PW-1:0] e_nn_reg, e_ms_reg, e_mm_reg;
    logic [MW-1:0] e_nu_reg, e_mu_reg, e_s_reg;
    logic [MW-1:0] f_t1_reg, f_t2_reg, f_t3_reg, f_t4_reg;
    logic [MW-1:0] nu_in;
    logic [PW-1:0] nn_rnd, ms_rnd, mm_rnd;

    assign nu_in  = ONE_M - s_side[MW-1:0];
    assign nn_rnd = e_nn_reg + HALF_P;
    assign ms_rnd = e_ms_reg + HALF_P;
    assign mm_rnd = e_mm_reg + HALF_P;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= s_valid;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_out_reg <= s_side[MW];
            e_nu_reg  <= nu_in;
            e_mu_reg  <= s_side[MW-1:0];
            e_s_reg   <= s_root;
            e_nn_reg  <= PW'(nu_in) * PW'(nu_in);
            e_ms_reg  <= PW'(s_side[MW-1:0]) * PW'(s_root);
            e_mm_reg  <= PW'(s_side[MW-1:0]) * PW'(s_side[MW-1:0]);
            f_out_reg <= e_out_reg;
            if (nonlinear)
            begin
                f_t1_reg <= ONE_M - e_s_reg;
                f_t2_reg <= ONE_M - e_mu_reg;
                f_t3_reg <= ONE_M - ms_rnd[F +: MW];
                f_t4_reg <= ONE_M - mm_rnd[F +: MW];
            end
            else
            begin
                // quadratic law: c3 and c4 see zero weight
                f_t1_reg <= e_nu_reg;
                f_t2_reg <= nn_rnd[F +: MW];
                f_t3_reg <= '0;
                f_t4_reg <= '0;
            end
        end
    end

    // g: coefficient products, h: limb factor, i: magnitude times scale
    logic                  g_valid_reg, h_valid_reg, i_valid_reg;
    logic                  g_out_reg, h_out_reg, i_out_reg;
    logic signed [CPW-1:0] g_p1_reg, g_p2_reg, g_p3_reg, g_p4_reg;
    logic signed [LW-1:0]  h_limb_reg;
    logic [LKW-1:0]        i_lk_reg;
    logic                  i_neg_reg;
    logic [LW-1:0]         limb_mag;

    assign limb_mag = h_limb_reg[LW-1] ? LW'(-h_limb_reg) : h_limb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_out_reg  <= f_out_reg;
            g_p1_reg   <= coeff1_reg * $signed({1'b0, f_t1_reg});
            g_p2_reg   <= coeff2_reg * $signed({1'b0, f_t2_reg});
            g_p3_reg   <= coeff3_reg * $signed({1'b0, f_t3_reg});
            g_p4_reg   <= coeff4_reg * $signed({1'b0, f_t4_reg});
            h_out_reg  <= g_out_reg;
            h_limb_reg <= ONE2_L - LW'(g_p1_reg) - LW'(g_p2_reg)
                                 - LW'(g_p3_reg) - LW'(g_p4_reg);
            i_out_reg  <= h_out_reg;
            i_neg_reg  <= h_limb_reg[LW-1];
            i_lk_reg   <= LKW'(limb_mag) * LKW'(k_scale);
        end
    end

    // j: partial products with the intensity, k: dividend
    logic           j_valid_reg, k_valid_reg;
    logic           j_out_reg, k_out_reg;
    logic           j_neg_reg, k_neg_reg;
    logic [PLW-1:0] j_lo_reg;
    logic [PHW-1:0] j_hi_reg;
    logic [NNW-1:0] k_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            j_valid_reg <= i_valid_reg;
            k_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_out_reg <= i_out_reg;
            j_neg_reg <= i_neg_reg;
            j_lo_reg  <= PLW'(int_mag_reg) * PLW'(i_lk_reg[H-1:0]);
            j_hi_reg  <= PHW'(int_mag_reg) * PHW'(i_lk_reg[LKW-1:H]);
            k_out_reg <= j_out_reg;
            k_neg_reg <= j_neg_reg;
            k_num_reg <= NNW'(j_lo_reg) + (NNW'(j_hi_reg) << H);
        end
    end

    logic          d_valid;
    logic [QW-1:0] d_quot;
    logic [DW-1:0] d_rem;
    logic          d_ovf;
    logic [1:0]    d_side;

    sdld_divider #(
        .DW  (DW),
        .QW  (QW),
        .SBW (2)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (k_valid_reg),
        .num       (k_num_reg),
        .divisor   (divisor_reg),
        .side_in   ({k_out_reg, k_neg_reg}),
        .out_valid (d_valid),
        .quot      (d_quot),
        .rem       (d_rem),
        .ovf       (d_ovf),
        .side_out  (d_side)
    );

    // round half away from zero, apply sign, saturate, pick by mode
    logic                 neg;
    logic [QW:0]          q_round;
    logic signed [IW-1:0] scaled;
    logic signed [IW-1:0] bright_next;
    logic                 undef_next;
    logic signed [IW-1:0] bright_reg;
    logic                 undef_reg;

    always_comb
    begin
        neg     = d_side[0] ^ int_neg_reg ^ norm_neg_reg;
        q_round = {1'b0, d_quot} + (QW+1)'({d_rem, 1'b0} >= {1'b0, divisor_reg});
        if (neg)
        begin
            if (d_ovf || q_round[QW:QW-1] != 2'b00)
                scaled = {1'b1, {(IW-1){1'b0}}};
            else
                scaled = IW'(-q_round[IW-1:0]);
        end
        else
        begin
            if (d_ovf || q_round[QW:QW-1] != 2'b00)
                scaled = {1'b0, {(IW-1){1'b1}}};
            else
                scaled = q_round[IW-1:0];
        end

        bright_next = '0;
        undef_next  = 1'b0;
        if (!d_side[1])
        begin
            case (mode_reg) inside
                sdld_pkg::MODE_NONE:     bright_next = '0;
                sdld_pkg::MODE_UNIFORM:  bright_next = intensity_reg;
                sdld_pkg::MODE_DAYNIGHT: bright_next = IW'(coeff1_reg);
                sdld_pkg::MODE_QUAD, sdld_pkg::MODE_NONLINEAR:
                begin
                    if (norm_zero_reg)
                        undef_next = 1'b1;
                    else
                        bright_next = scaled;
                end
                default: undef_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bright_reg <= bright_next;
            undef_reg  <= undef_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign brightness = bright_reg;
    assign undefined  = undef_reg;

`include "stellar_disk_limb_darkening_defines.svh"

    `SDLD_ASSERT_IMP(a_undef_zero, out_valid && undefined, brightness == '0)
    `SDLD_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(brightness) && $stable(undefined))

endmodule
